>>> rtl/bank_switch_irq_mapper_assert.svh
// assertion macros for the bank switch irq mapper
`ifndef BANK_SWITCH_IRQ_MAPPER_ASSERT_SVH
`define BANK_SWITCH_IRQ_MAPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define BSIM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bsim check failed");
`define BSIM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bsim check failed");
`else
`define BSIM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BSIM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/bsim_pkg.sv
// types, codes and constants shared by the bank switch irq mapper
package bsim_pkg;
	localparam int MEM_ADDR_W = 21;
	localparam int PRG_ADDR_BITS_DEF = 21;
	localparam int CHR_ADDR_BITS_DEF = 18;
	localparam int WRAM_BYTES = 8192;
	localparam int WRAM_AW = $clog2(WRAM_BYTES);
	localparam int CFG_IDX_W = 1;

	// request kinds
	localparam logic [1:0] FN_CPU_WRITE = 2'd0;
	localparam logic [1:0] FN_CPU_READ = 2'd1;
	localparam logic [1:0] FN_PPU = 2'd2;
	localparam logic [1:0] FN_TICK = 2'd3;

	// result targets
	localparam logic [2:0] TGT_NONE = 3'd0;
	localparam logic [2:0] TGT_PRG = 3'd1;
	localparam logic [2:0] TGT_WRAM = 3'd2;
	localparam logic [2:0] TGT_OPEN = 3'd3;
	localparam logic [2:0] TGT_CHR = 3'd4;
	localparam logic [2:0] TGT_NTRAM = 3'd5;

	// $F000 page registers, decoded by a[1:0]
	localparam logic [1:0] FREG_RELOAD = 2'd0;
	localparam logic [1:0] FREG_CONTROL = 2'd1;
	localparam logic [1:0] FREG_MIRROR = 2'd2;

	// mirroring modes
	localparam logic [1:0] MIR_HORZ = 2'd0;
	localparam logic [1:0] MIR_VERT = 2'd1;
	localparam logic [1:0] MIR_PAGE0 = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_MASK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_MASK = 1'd1;

	typedef struct packed {
		logic [1:0] func;
		logic [15:0] addr;
		logic [7:0] data;
		logic [7:0] ticks;
	} req_t;

	typedef struct packed {
		logic [2:0] target;
		logic [MEM_ADDR_W-1:0] mem_addr;
		logic write_enable;
		logic irq;
	} rsp_t;

	typedef struct packed {
		logic [3:0][7:0] prg_bank;
		logic [7:0][7:0] chr_bank;
		logic [1:0] mirror;
	} bank_state_t;
endpackage

>>> rtl/bsim_regs.sv
// bank registers, mirroring and the irq counter, updated once per request
module bsim_regs (
	input logic clk,
	input logic arst_n,
	input logic upd,
	input bsim_pkg::req_t req,
	output bsim_pkg::bank_state_t st,
	output logic irq_next
);
	import bsim_pkg::*;

	logic [3:0][7:0] prg_bank_q;
	logic [7:0][7:0] chr_bank_q;
	logic [1:0] mirror_q;
	logic [3:0] irq_ctrl_q;
	logic [15:0] irq_cnt_q;
	logic [15:0] irq_reload_q;
	logic irq_pend_q;

	logic is_wr;
	logic [15:0] a;
	logic [15:0] chr_off;
	logic [1:0] prg_idx;
	logic [2:0] chr_idx;
	logic [15:0] cnt_mask;
	logic [15:0] part;
	logic [15:0] ticks_w;
	logic [15:0] new_part;
	logic tick_go;

	assign a = req.addr;
	assign is_wr = (req.func == FN_CPU_WRITE);
	assign chr_off = a - 16'hA000;
	assign prg_idx = {a[12], a[1]};
	assign chr_idx = {chr_off[13:12], a[1]};

	// counting width picked by the control nibble
	always_comb begin
		if (irq_ctrl_q[3]) begin
			cnt_mask = 16'h000F;
		end else if (irq_ctrl_q[2]) begin
			cnt_mask = 16'h00FF;
		end else if (irq_ctrl_q[1]) begin
			cnt_mask = 16'h0FFF;
		end else begin
			cnt_mask = 16'hFFFF;
		end
	end

	assign part = irq_cnt_q & cnt_mask;
	assign ticks_w = {8'h00, req.ticks};
	assign tick_go = (req.func == FN_TICK) && irq_ctrl_q[0] && (part != 16'h0000)
		&& (req.ticks != 8'h00);
	// count down, stopping at zero
	assign new_part = (ticks_w < part) ? (part - ticks_w) : 16'h0000;

	always_comb begin
		irq_next = irq_pend_q;
		if (is_wr && (a[15:12] == 4'hF)
			&& ((a[1:0] == FREG_RELOAD) || (a[1:0] == FREG_CONTROL))) begin
			irq_next = 1'b0;
		end
		if (tick_go && (new_part == 16'h0000)) begin
			irq_next = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_q <= {8'h00, 8'hFE, 8'h01, 8'h00};
			chr_bank_q <= '0;
			mirror_q <= MIR_HORZ;
			irq_ctrl_q <= 4'h0;
			irq_cnt_q <= 16'h0000;
			irq_reload_q <= 16'h0000;
			irq_pend_q <= 1'b0;
		end else if (upd) begin
			irq_pend_q <= irq_next;
			if (tick_go) begin
				irq_cnt_q <= (irq_cnt_q & ~cnt_mask) | new_part;
			end
			if (is_wr) begin
				if (a[15:13] == 3'b100) begin
					if (a[0]) begin
						prg_bank_q[prg_idx][7:4] <= req.data[3:0];
					end else begin
						prg_bank_q[prg_idx][3:0] <= req.data[3:0];
					end
				end else if ((a[15:13] == 3'b101) || (a[15:13] == 3'b110)) begin
					if (a[0]) begin
						chr_bank_q[chr_idx][7:4] <= req.data[3:0];
					end else begin
						chr_bank_q[chr_idx][3:0] <= req.data[3:0];
					end
				end else if (a[15:12] == 4'hE) begin
					irq_reload_q[{a[1:0], 2'b00} +: 4] <= req.data[3:0];
				end else if (a[15:12] == 4'hF) begin
					case (a[1:0])
						FREG_RELOAD: begin
							irq_cnt_q <= irq_reload_q;
						end
						FREG_CONTROL: begin
							irq_ctrl_q <= req.data[3:0];
						end
						FREG_MIRROR: begin
							mirror_q <= req.data[1:0];
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	assign st.prg_bank = prg_bank_q;
	assign st.chr_bank = chr_bank_q;
	assign st.mirror = mirror_q;
endmodule

>>> rtl/bsim_xlate.sv
// address translation for cpu and ppu requests
module bsim_xlate #(
	parameter int PRG_ADDR_BITS = bsim_pkg::PRG_ADDR_BITS_DEF,
	parameter int CHR_ADDR_BITS = bsim_pkg::CHR_ADDR_BITS_DEF
) (
	input bsim_pkg::req_t req,
	input bsim_pkg::bank_state_t st,
	input logic [7:0] prg_mask,
	input logic [7:0] chr_mask,
	output logic [2:0] target,
	output logic [bsim_pkg::MEM_ADDR_W-1:0] mem_addr,
	output logic write_enable
);
	import bsim_pkg::*;

	localparam logic [MEM_ADDR_W-1:0] PRG_WRAP =
		MEM_ADDR_W'((64'd1 << PRG_ADDR_BITS) - 64'd1);
	localparam logic [17:0] CHR_WRAP = 18'((64'd1 << CHR_ADDR_BITS) - 64'd1);

	logic [15:0] a;
	logic [7:0] pbank;
	logic [7:0] cbank;
	logic [MEM_ADDR_W-1:0] prg_addr;
	logic [17:0] chr_addr;
	logic [MEM_ADDR_W-1:0] wram_addr;
	logic page;

	assign a = req.addr;
	assign pbank = ((a[14:13] == 2'b11) ? 8'hFF : st.prg_bank[a[14:13]]) & prg_mask;
	assign cbank = st.chr_bank[a[12:10]] & chr_mask;
	assign prg_addr = {pbank, a[12:0]} & PRG_WRAP;
	assign chr_addr = {cbank, a[9:0]} & CHR_WRAP;
	assign wram_addr = MEM_ADDR_W'(a[WRAM_AW-1:0]);

	always_comb begin
		case (st.mirror)
			MIR_HORZ: page = a[11];
			MIR_VERT: page = a[10];
			MIR_PAGE0: page = 1'b0;
			default: page = 1'b1;
		endcase
	end

	always_comb begin
		target = TGT_NONE;
		mem_addr = '0;
		write_enable = 1'b0;
		case (req.func)
			FN_CPU_WRITE: begin
				if ((a[15:13] == 3'b011) && (st.prg_bank[3][1:0] == 2'b11)) begin
					target = TGT_WRAM;
					mem_addr = wram_addr;
					write_enable = 1'b1;
				end
			end
			FN_CPU_READ: begin
				if (a[15]) begin
					target = TGT_PRG;
					mem_addr = prg_addr;
				end else if (a[14:13] == 2'b11) begin
					if (st.prg_bank[3][0]) begin
						target = TGT_WRAM;
						mem_addr = wram_addr;
					end else begin
						target = TGT_OPEN;
					end
				end
			end
			FN_PPU: begin
				if (!a[13]) begin
					target = TGT_CHR;
					mem_addr = MEM_ADDR_W'(chr_addr);
				end else if (a[13:8] != 6'h3F) begin
					// nametable area, palette excluded
					target = TGT_NTRAM;
					mem_addr = MEM_ADDR_W'({page, a[9:0]});
				end
			end
			default: begin
			end
		endcase
	end
endmodule

>>> rtl/bank_switch_irq_mapper.sv
// top level of the bank switch irq mapper
//
// channel  dir  handshake               payload
// req      in   req_valid / req_stall   req (func, addr, data, ticks)
// rsp      out  rsp_valid / rsp_stall   rsp (target, mem_addr, write_enable, irq)
// cfg      in   cfg_valid / cfg_ready   cfg_index, cfg_wdata
//
// one request per cycle while req_stall is low; its result reaches rsp through the
// input register, then translation and state update into the output register
// reset returns banks, mirroring, counter and irq to their power-up values
// req_stall rises only while the input register is full and the output register
// holds a result that the receiver stalls
`include "bank_switch_irq_mapper_assert.svh"
module bank_switch_irq_mapper #(
	parameter int PRG_ADDR_BITS = bsim_pkg::PRG_ADDR_BITS_DEF,
	parameter int CHR_ADDR_BITS = bsim_pkg::CHR_ADDR_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input bsim_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output bsim_pkg::rsp_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [bsim_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [7:0] cfg_wdata
);
	import bsim_pkg::*;

	logic s1_valid_q;
	req_t req_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic [7:0] prg_mask_q;
	logic [7:0] chr_mask_q;
	logic advance;
	bank_state_t st;
	logic irq_next;
	rsp_t rsp_d;
	logic rsp_no_tgt;

	assign advance = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = s1_valid_q && !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_mask_q <= 8'hFF;
			chr_mask_q <= 8'hFF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PRG_MASK: prg_mask_q <= cfg_wdata;
				CFG_CHR_MASK: chr_mask_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!req_stall) begin
			s1_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	bsim_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.upd(advance),
		.req(req_s1),
		.st(st),
		.irq_next(irq_next)
	);

	bsim_xlate #(
		.PRG_ADDR_BITS(PRG_ADDR_BITS),
		.CHR_ADDR_BITS(CHR_ADDR_BITS)
	) u_xlate (
		.req(req_s1),
		.st(st),
		.prg_mask(prg_mask_q),
		.chr_mask(chr_mask_q),
		.target(rsp_d.target),
		.mem_addr(rsp_d.mem_addr),
		.write_enable(rsp_d.write_enable)
	);

	assign rsp_d.irq = irq_next;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign rsp_no_tgt = (rsp.target == TGT_NONE) || (rsp.target == TGT_OPEN);

	`BSIM_ASSERT_IMPLY(a_we_wram, clk, arst_n, rsp_valid && rsp.write_enable, rsp.target == TGT_WRAM)
	`BSIM_ASSERT_IMPLY(a_no_addr, clk, arst_n, rsp_valid && rsp_no_tgt, rsp.mem_addr == '0)
	`BSIM_ASSERT_IMPLY(a_stall_full, clk, arst_n, req_stall, s1_valid_q && rsp_valid_q)
	`BSIM_ASSERT_NEXT(a_adv_out, clk, arst_n, advance, rsp_valid)
endmodule

>>> verif/bank_switch_irq_mapper_tb.sv
// self-checking testbench for the bank switch irq mapper: directed table, then random requests
`timescale 1ns / 100ps
module bank_switch_irq_mapper_tb;
	import bsim_pkg::*;

	localparam int PRG_BITS = PRG_ADDR_BITS_DEF;
	localparam int CHR_BITS = CHR_ADDR_BITS_DEF;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 200;

	typedef struct {
		req_t item;
		bit typed;
		rsp_t want;
	} step_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0] cfg_wdata;

	// mapper state as predicted
	logic [7:0] prg_mask_m;
	logic [7:0] chr_mask_m;
	logic [7:0] prg_bank_m [4];
	logic [7:0] chr_bank_m [8];
	logic [1:0] mirror_m;
	logic [3:0] irq_ctl_m;
	logic [15:0] irq_cnt_m;
	logic [15:0] irq_rld_m;
	logic irq_pend_m;

	rsp_t mapped_q [$];
	step_t directed [$];
	bit idle_on = 1'b1;
	int sent = 0;
	int errors = 0;
	int unsigned cycles = 0;

	bank_switch_irq_mapper u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// translates one request and advances the predicted state
	function automatic rsp_t map_access(input req_t r);
		rsp_t o;
		logic [15:0] a;
		logic [15:0] offs;
		logic [13:0] pa;
		logic [1:0] idx;
		logic [7:0] bank;
		logic [31:0] lin;
		logic [15:0] span;
		logic [15:0] part;
		logic [15:0] dec;
		logic page;
		o = '0;
		a = r.addr;
		case (r.func)
			FN_CPU_WRITE: begin
				if (a >= 16'h6000 && a < 16'h8000) begin
					if (prg_bank_m[3][1:0] == 2'b11) begin
						o.target = TGT_WRAM;
						o.write_enable = 1'b1;
						o.mem_addr = 21'(a[12:0]);
					end
				end else if (a >= 16'h8000 && a < 16'hA000) begin
					idx = {a[12], a[1]};
					prg_bank_m[idx] = a[0] ? {r.data[3:0], prg_bank_m[idx][3:0]}
						: {prg_bank_m[idx][7:4], r.data[3:0]};
				end else if (a >= 16'hA000 && a < 16'hE000) begin
					offs = a - 16'hA000;
					chr_bank_m[{offs[13:12], a[1]}] = a[0]
						? {r.data[3:0], chr_bank_m[{offs[13:12], a[1]}][3:0]}
						: {chr_bank_m[{offs[13:12], a[1]}][7:4], r.data[3:0]};
				end else if (a >= 16'hE000 && a < 16'hF000) begin
					irq_rld_m[a[1:0]*4 +: 4] = r.data[3:0];
				end else if (a >= 16'hF000) begin
					case (a[1:0])
						FREG_RELOAD: begin
							irq_cnt_m = irq_rld_m;
							irq_pend_m = 1'b0;
						end
						FREG_CONTROL: begin
							irq_ctl_m = r.data[3:0];
							irq_pend_m = 1'b0;
						end
						FREG_MIRROR: mirror_m = r.data[1:0];
						default: ;
					endcase
				end
			end
			FN_CPU_READ: begin
				if (a >= 16'h8000) begin
					bank = (a[14:13] == 2'b11) ? 8'hFF : prg_bank_m[a[14:13]];
					bank &= prg_mask_m;
					lin = {11'd0, bank, a[12:0]} & ((32'd1 << PRG_BITS) - 1);
					o.target = TGT_PRG;
					o.mem_addr = lin[20:0];
				end else if (a >= 16'h6000) begin
					if (prg_bank_m[3][0]) begin
						o.target = TGT_WRAM;
						o.mem_addr = 21'(a[12:0]);
					end else begin
						o.target = TGT_OPEN;
					end
				end
			end
			FN_PPU: begin
				pa = a[13:0];
				if (pa < 14'h2000) begin
					bank = chr_bank_m[pa[12:10]] & chr_mask_m;
					lin = {14'd0, bank, pa[9:0]} & ((32'd1 << CHR_BITS) - 1);
					o.target = TGT_CHR;
					o.mem_addr = lin[20:0];
				end else if (pa < 14'h3F00) begin
					case (mirror_m)
						MIR_HORZ: page = pa[11];
						MIR_VERT: page = pa[10];
						MIR_PAGE0: page = 1'b0;
						default: page = 1'b1;
					endcase
					o.target = TGT_NTRAM;
					o.mem_addr = 21'({page, pa[9:0]});
				end
			end
			default: begin
				if (irq_ctl_m[0]) begin
					if (irq_ctl_m[3])
						span = 16'h000F;
					else if (irq_ctl_m[2])
						span = 16'h00FF;
					else if (irq_ctl_m[1])
						span = 16'h0FFF;
					else
						span = 16'hFFFF;
					part = irq_cnt_m & span;
					if (part != 16'd0 && r.ticks != 8'd0) begin
						dec = (16'(r.ticks) < part) ? 16'(r.ticks) : part;
						part -= dec;
						irq_cnt_m = (irq_cnt_m & ~span) | part;
						if (part == 16'd0)
							irq_pend_m = 1'b1;
					end
				end
			end
		endcase
		o.irq = irq_pend_m;
		return o;
	endfunction

	function automatic step_t row(input logic [1:0] f, input logic [15:0] a,
		input logic [7:0] d, input logic [7:0] n, input bit typed = 1'b0,
		input logic [2:0] tgt = TGT_NONE, input logic [20:0] ma = '0, input logic we = 1'b0);
		step_t s;
		s.item = '{func: f, addr: a, data: d, ticks: n};
		s.typed = typed;
		s.want = '{target: tgt, mem_addr: ma, write_enable: we, irq: 1'b0};
		return s;
	endfunction

	function automatic req_t rand_req();
		req_t r;
		int pick;
		r.func = FN_CPU_READ;
		r.addr = 16'($urandom);
		r.data = 8'($urandom);
		r.ticks = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			r.func = FN_CPU_WRITE;
			case ($urandom_range(0, 5))
				0: ;
				1: r.addr = 16'h6000 + 16'($urandom_range(0, 'h1FFF));
				2: r.addr = 16'h8000 + 16'($urandom_range(0, 'h1FFF));
				3: r.addr = 16'hA000 + 16'($urandom_range(0, 'h3FFF));
				4: r.addr = 16'hE000 + 16'($urandom_range(0, 'h0FFF));
				default: r.addr = 16'hF000 + 16'($urandom_range(0, 'h0FFF));
			endcase
		end else if (pick < 55) begin
			case ($urandom_range(0, 2))
				0: ;
				1: r.addr = 16'h6000 + 16'($urandom_range(0, 'h1FFF));
				default: r.addr[15] = 1'b1;
			endcase
		end else if (pick < 80) begin
			r.func = FN_PPU;
			if ($urandom_range(0, 1) == 0)
				r.addr[13] = 1'b0;
		end else begin
			r.func = FN_TICK;
			if ($urandom_range(0, 1) == 0)
				r.ticks = 8'($urandom_range(0, 15));
		end
		return r;
	endfunction

	// holds the request until it is taken, then records what should come back
	task automatic send_req(input req_t r, input bit typed, input rsp_t typed_rsp);
		int gap;
		rsp_t model_rsp;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		model_rsp = map_access(r);
		mapped_q.push_back(typed ? typed_rsp : model_rsp);
		sent++;
	endtask

	// reload value, counter reload and control, then a run of ticks
	task automatic arm_counter();
		req_t r;
		int k;
		int runs;
		r = '0;
		r.func = FN_CPU_WRITE;
		for (k = 0; k < 4; k++) begin
			r.addr = {4'hE, 10'($urandom), 2'(k)};
			r.data = 8'($urandom);
			if (k >= 2 && $urandom_range(0, 3) != 0)
				r.data[3:0] = 4'd0;
			send_req(r, 1'b0, '0);
		end
		r.addr = {4'hF, 10'($urandom), FREG_RELOAD};
		send_req(r, 1'b0, '0);
		r.addr = {4'hF, 10'($urandom), FREG_CONTROL};
		r.data = 8'($urandom);
		r.data[0] = ($urandom_range(0, 7) != 0);
		send_req(r, 1'b0, '0);
		runs = $urandom_range(2, 12);
		for (k = 0; k < runs; k++) begin
			r = '0;
			r.func = FN_TICK;
			r.ticks = 8'($urandom);
			r.addr = 16'($urandom);
			send_req(r, 1'b0, '0);
		end
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (mapped_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_masks(input logic [7:0] pm, input logic [7:0] cm);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_PRG_MASK;
		cfg_wdata <= pm;
		do @(posedge clk); while (!cfg_ready);
		prg_mask_m = pm;
		cfg_index <= CFG_CHR_MASK;
		cfg_wdata <= cm;
		do @(posedge clk); while (!cfg_ready);
		chr_mask_m = cm;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (mapped_q.size() == 0) begin
				$error("response with nothing outstanding: %p", rsp);
				errors++;
			end else begin
				want = mapped_q.pop_front();
				if (rsp.target !== want.target) begin
					$error("target: expected %0d, got %0d", want.target, rsp.target);
					errors++;
				end
				if (rsp.mem_addr !== want.mem_addr) begin
					$error("mem_addr: expected %h, got %h", want.mem_addr, rsp.mem_addr);
					errors++;
				end
				if (rsp.write_enable !== want.write_enable) begin
					$error("write_enable: expected %b, got %b", want.write_enable,
						rsp.write_enable);
					errors++;
				end
				if (rsp.irq !== want.irq) begin
					$error("irq: expected %b, got %b", want.irq, rsp.irq);
					errors++;
				end
			end
		end
	end

	initial begin : rsp_side
		int hold;
		rsp_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = idle_on ? $urandom_range(0, 3) : 0;
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
		end
	end

	initial begin : stimulus
		int phase;
		int goal;
		logic [7:0] pm;
		logic [7:0] cm;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PRG_MASK;
		cfg_wdata = 8'd0;
		prg_mask_m = 8'hFF;
		chr_mask_m = 8'hFF;
		prg_bank_m = '{8'h00, 8'h01, 8'hFE, 8'h00};
		chr_bank_m = '{default: 8'h00};
		mirror_m = MIR_HORZ;
		irq_ctl_m = 4'd0;
		irq_cnt_m = 16'd0;
		irq_rld_m = 16'd0;
		irq_pend_m = 1'b0;

		// power-up banks, disabled work ram, palette and idle counter first
		directed.push_back(row(FN_CPU_READ, 16'h8000, 8'h00, 8'h00, 1, TGT_PRG, 21'h000000));
		directed.push_back(row(FN_CPU_READ, 16'hA000, 8'h00, 8'h00, 1, TGT_PRG, 21'h002000));
		directed.push_back(row(FN_CPU_READ, 16'hC000, 8'h00, 8'h00, 1, TGT_PRG, 21'h1FC000));
		directed.push_back(row(FN_CPU_READ, 16'hFFFF, 8'hFF, 8'hFF, 1, TGT_PRG, 21'h1FFFFF));
		directed.push_back(row(FN_CPU_READ, 16'h6000, 8'h00, 8'h00, 1, TGT_OPEN));
		directed.push_back(row(FN_CPU_READ, 16'h0000, 8'h00, 8'h00, 1, TGT_NONE));
		directed.push_back(row(FN_CPU_WRITE, 16'h6000, 8'hFF, 8'h00, 1, TGT_NONE));
		directed.push_back(row(FN_PPU, 16'h0000, 8'h00, 8'h00, 1, TGT_CHR, 21'h000000));
		directed.push_back(row(FN_PPU, 16'h2800, 8'h00, 8'h00, 1, TGT_NTRAM, 21'h000400));
		directed.push_back(row(FN_PPU, 16'hFFFF, 8'hFF, 8'hFF, 1, TGT_NONE));
		directed.push_back(row(FN_TICK, 16'h0000, 8'h00, 8'hFF, 1, TGT_NONE));
		// enable work ram, then write through at the top of the window
		directed.push_back(row(FN_CPU_WRITE, 16'h9002, 8'hF3, 8'h00, 1, TGT_NONE));
		directed.push_back(row(FN_CPU_WRITE, 16'h7FFF, 8'h5A, 8'h00, 1, TGT_WRAM, 21'h001FFF,
			1'b1));
		directed.push_back(row(FN_CPU_READ, 16'h6000, 8'h00, 8'h00));
		directed.push_back(row(FN_CPU_WRITE, 16'hA001, 8'h0F, 8'h00));
		directed.push_back(row(FN_PPU, 16'h03FF, 8'h00, 8'h00));
		directed.push_back(row(FN_CPU_WRITE, 16'hDFFF, 8'h07, 8'h00));
		directed.push_back(row(FN_PPU, 16'h1C00, 8'h00, 8'h00));
		// short 4-bit count down to the irq, then a zero-length tick
		directed.push_back(row(FN_CPU_WRITE, 16'hE000, 8'h05, 8'h00));
		directed.push_back(row(FN_CPU_WRITE, 16'hF000, 8'h00, 8'h00));
		directed.push_back(row(FN_CPU_WRITE, 16'hF001, 8'h09, 8'h00));
		directed.push_back(row(FN_TICK, 16'h0000, 8'h00, 8'h03));
		directed.push_back(row(FN_TICK, 16'h0000, 8'h00, 8'hFF));
		directed.push_back(row(FN_TICK, 16'h0000, 8'h00, 8'h00));
		directed.push_back(row(FN_CPU_WRITE, 16'hF002, 8'hFF, 8'h00));
		directed.push_back(row(FN_PPU, 16'h2000, 8'h00, 8'h00));
		directed.push_back(row(FN_CPU_WRITE, 16'hF003, 8'hFF, 8'h00));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_req(directed[i].item, directed[i].typed, directed[i].want);

		for (phase = 0; phase < 8; phase++) begin
			settle();
			case (phase)
				0: begin pm = 8'hFF; cm = 8'hFF; end
				1: begin pm = 8'h00; cm = 8'h00; end
				2: begin pm = 8'hFF; cm = 8'h00; end
				3: begin pm = 8'h00; cm = 8'hFF; end
				default: begin pm = 8'($urandom); cm = 8'($urandom); end
			endcase
			load_masks(pm, cm);
			// two phases run with both sides at full rate
			idle_on = !(phase == 2 || phase == 5);
			goal = sent + PHASE_ITEMS;
			while (sent < goal) begin
				if ($urandom_range(0, 99) < 8)
					arm_counter();
				else
					send_req(rand_req(), 1'b0, '0);
			end
		end
		settle();

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
